>>> design/two_finger_edge_swipe_detector_top_defines.svh
// Assertion macros shared by the swipe detector checker.
`ifndef TWO_FINGER_EDGE_SWIPE_DETECTOR_TOP_DEFINES_SVH
`define TWO_FINGER_EDGE_SWIPE_DETECTOR_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TFES_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TFES_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tfes_pkg.sv
// Shared types, codes and constants of the two-finger edge swipe detector.
package tfes_pkg;

	localparam int COORD_BITS_DEF   = 16;
	localparam int FINGER_LIMIT_DEF = 15;

	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int VALUE_BITS   = 17;
	localparam int MAG_BITS     = VALUE_BITS - 1;

	// Register indexes on the write port.
	localparam logic [CFG_IDX_BITS-1:0] CFG_X_MIN     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_X_MAX     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_BAND = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ARM_THR   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SWIPE_THR = 3'd4;

	localparam logic [CFG_BITS-1:0] X_MIN_RST     = 16'd0;
	localparam logic [CFG_BITS-1:0] X_MAX_RST     = 16'd65535;
	localparam logic [CFG_BITS-1:0] EDGE_BAND_RST = 16'd21845;
	localparam logic [CFG_BITS-1:0] ARM_THR_RST   = 16'd3276;
	localparam logic [CFG_BITS-1:0] SWIPE_THR_RST = 16'd5461;

	typedef enum logic [1:0] {
		OP_OTHER   = 2'd0,
		OP_CONTACT = 2'd1,
		OP_X       = 2'd2,
		OP_Y       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KEY_VOL_UP     = 2'd0,
		KEY_VOL_DOWN   = 2'd1,
		KEY_BRIGHT_UP  = 2'd2,
		KEY_BRIGHT_DOWN = 2'd3
	} key_t;

	typedef enum logic [1:0] {
		ZONE_NONE  = 2'd0,
		ZONE_RIGHT = 2'd1,
		ZONE_LEFT  = 2'd2
	} zone_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] x_min;
		logic [CFG_BITS-1:0] x_max;
		logic [CFG_BITS-1:0] edge_band_width;
		logic [CFG_BITS-1:0] arm_threshold;
		logic [CFG_BITS-1:0] swipe_threshold;
	} cfg_t;

	typedef struct packed {
		op_t                    op;
		logic signed [VALUE_BITS-1:0] value;
	} item_t;

	typedef struct packed {
		logic hit;
		key_t key;
	} res_t;

endpackage

>>> design/tfes_cfg.sv
// Configuration register bank of the swipe detector.
module tfes_cfg import tfes_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min           <= X_MIN_RST;
			cfg_q.x_max           <= X_MAX_RST;
			cfg_q.edge_band_width <= EDGE_BAND_RST;
			cfg_q.arm_threshold   <= ARM_THR_RST;
			cfg_q.swipe_threshold <= SWIPE_THR_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_X_MIN:     cfg_q.x_min           <= cfg_data;
				CFG_X_MAX:     cfg_q.x_max           <= cfg_data;
				CFG_EDGE_BAND: cfg_q.edge_band_width <= cfg_data;
				CFG_ARM_THR:   cfg_q.arm_threshold   <= cfg_data;
				CFG_SWIPE_THR: cfg_q.swipe_threshold <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/tfes_core.sv
// Gesture state and the per-event update: finger count, coordinates, zone, arm and fire.
module tfes_core import tfes_pkg::*; #(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int FINGER_LIMIT = FINGER_LIMIT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step_en,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	localparam int FB = $clog2(FINGER_LIMIT + 1);
	localparam int CW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;
	localparam logic [FB-1:0] F_LIMIT = FB'(FINGER_LIMIT);
	localparam logic [FB-1:0] F_ONE   = FB'(1);
	localparam logic [FB-1:0] F_TWO   = FB'(2);

	logic [FB-1:0]         finger_q;
	logic [COORD_BITS-1:0] start_x_q, start_y_q, now_x_q, now_y_q;
	zone_t                 zone_q;
	logic                  armed_q, fired_q;

	logic [FB-1:0]         finger_d;
	logic [COORD_BITS-1:0] start_x_d, start_y_d, now_x_d, now_y_d;
	zone_t                 zone_d;
	logic                  armed_d, fired_d;

	logic [COORD_BITS-1:0] coord_in;
	logic [COORD_BITS-1:0] dx, dy;
	logic                  lift, two_down, travel_ok, zone_right, zone_left;
	logic [CW-1:0]         x_w;

	// Clamp the signed event value onto the coordinate range.
	generate
		if (COORD_BITS >= MAG_BITS) begin : g_wide
			assign coord_in = item.value[VALUE_BITS-1] ? '0
				: COORD_BITS'(item.value[MAG_BITS-1:0]);
		end else begin : g_narrow
			logic over;
			assign over     = |item.value[MAG_BITS-1:COORD_BITS];
			assign coord_in = item.value[VALUE_BITS-1] ? '0
				: (over ? '1 : item.value[COORD_BITS-1:0]);
		end
	endgenerate

	assign lift = (item.value == '1);

	// Zone bounds, widened so neither side wraps.
	assign x_w        = CW'(coord_in);
	assign zone_right = (x_w + CW'(cfg.edge_band_width)) > CW'(cfg.x_max);
	assign zone_left  = x_w < (CW'(cfg.x_min) + CW'(cfg.edge_band_width));

	always_comb begin
		finger_d  = finger_q;
		start_x_d = start_x_q;
		start_y_d = start_y_q;
		now_x_d   = now_x_q;
		now_y_d   = now_y_q;
		zone_d    = zone_q;
		armed_d   = armed_q;
		fired_d   = fired_q;
		res.hit   = 1'b0;
		res.key   = KEY_VOL_UP;

		case (item.op)
			OP_CONTACT: begin
				if (lift) begin
					if (finger_q != '0) finger_d = finger_q - F_ONE;
				end else begin
					if (finger_q == '0) begin
						start_x_d = now_x_q;
						start_y_d = now_y_q;
						armed_d   = 1'b0;
						fired_d   = 1'b0;
					end
					if (finger_q < F_LIMIT) finger_d = finger_q + F_ONE;
				end
			end
			OP_X: begin
				now_x_d = coord_in;
				if (finger_q == F_ONE) begin
					start_x_d = coord_in;
					zone_d    = zone_right ? ZONE_RIGHT : (zone_left ? ZONE_LEFT : ZONE_NONE);
				end
			end
			OP_Y: begin
				now_y_d = coord_in;
				if (finger_q == F_ONE) start_y_d = coord_in;
			end
			default: begin
				// other events only run the gesture checks
			end
		endcase

		dx        = (now_x_d >= start_x_d) ? now_x_d - start_x_d : start_x_d - now_x_d;
		dy        = (now_y_d >= start_y_d) ? now_y_d - start_y_d : start_y_d - now_y_d;
		travel_ok = dy > dx;
		two_down  = (finger_d == F_TWO);

		if (two_down && !armed_d && travel_ok
				&& CW'(dy) > CW'(cfg.arm_threshold)) begin
			armed_d = 1'b1;
		end

		if (armed_d && two_down && zone_d != ZONE_NONE && !fired_d && travel_ok
				&& CW'(dy) > CW'(cfg.swipe_threshold)) begin
			res.hit = 1'b1;
			case (zone_d)
				ZONE_RIGHT: res.key = (now_y_d < start_y_d) ? KEY_VOL_UP : KEY_VOL_DOWN;
				default:    res.key = (now_y_d < start_y_d) ? KEY_BRIGHT_UP : KEY_BRIGHT_DOWN;
			endcase
			fired_d   = 1'b1;
			start_y_d = now_y_d;
		end

		if (finger_d == '0) begin
			armed_d = 1'b0;
			fired_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finger_q  <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			now_x_q   <= '0;
			now_y_q   <= '0;
			zone_q    <= ZONE_NONE;
			armed_q   <= 1'b0;
			fired_q   <= 1'b0;
		end else if (step_en) begin
			finger_q  <= finger_d;
			start_x_q <= start_x_d;
			start_y_q <= start_y_d;
			now_x_q   <= now_x_d;
			now_y_q   <= now_y_d;
			zone_q    <= zone_d;
			armed_q   <= armed_d;
			fired_q   <= fired_d;
		end
	end

endmodule

>>> design/two_finger_edge_swipe_detector_top.sv
// Top level of the two-finger edge swipe detector.
//
//  channel | signals                         | direction | beat
//  --------+---------------------------------+-----------+--------------------------------
//  in      | in_valid, in_ready, op, value   | sink      | one touch event
//  out     | out_valid, out_ready, key       | source    | one key code, zero or one per event
//  cfg     | cfg_we, cfg_idx, cfg_data       | sink      | one register write, no wait
//
// An event beat lands in the input register, the gesture state updates from it when the
// event steps, and any key lands in the output register alongside that state update.
// One event per cycle is sustained while the output register is free; the state update
// is the limiting loop. A key waiting in the output register does not block intake: the
// input register holds one more beat, and in_ready drops only when both registers are full.
// Reset clears the finger count, coordinates, zone, flags and both valids.
module two_finger_edge_swipe_detector_top import tfes_pkg::*; #(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int FINGER_LIMIT = FINGER_LIMIT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   key,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_idx,
	input  logic [CFG_BITS-1:0]          cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	logic  out_valid_q;
	key_t  key_q;
	logic  out_free, step;

	// The output slot is free when empty or when its key leaves this cycle.
	assign out_free = !out_valid_q || out_ready;
	// Advance the held event into the state whenever its result has a place to go.
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	tfes_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Input register: hold one event beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op    <= op_t'(op);
			item_s1.value <= value;
		end
	end

	tfes_core #(
		.COORD_BITS   (COORD_BITS),
		.FINGER_LIMIT (FINGER_LIMIT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Output register: load a key when the event fires, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.hit) begin
			key_q <= res.key;
		end
	end

	assign out_valid = out_valid_q;
	assign key       = key_q;

endmodule

>>> design/tfes_checker.sv
// Port-level checker for the swipe detector, bound to the top level.
`include "two_finger_edge_swipe_detector_top_defines.svh"

module tfes_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] key
);

	// A key not taken stays put.
	`TFES_ASSERT(a_key_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(key), "key beat changed while stalled")

	// Intake stalls only behind a key that is stuck in the output register.
	`TFES_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

	// No key is shown while reset is applied.
	`TFES_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "key valid during reset")

endmodule

bind two_finger_edge_swipe_detector_top tfes_checker u_tfes_checker (.*);
